>>> src/bpq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Field widths, command and status codes, controller states and the command
// and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

   // Command codes carried by req_cmd.
   localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_HEAD = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_MAX  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROTATE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INSERT,
      ST_SCAN
   } bpq_state_type;

   // Source of the result value.
   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_ONES,
      RSP_HEAD,
      RSP_BEST
   } rsp_src_type;

   typedef struct packed {
      logic                load;
      logic                op_append;
      logic                op_flags;
      logic                op_insert;
      logic                op_remove;
      logic                use_best;
      logic                op_rotate;
      logic                op_clear;
      logic                scan_init;
      logic                scan_step;
      logic                respond;
      logic [STATUS_W-1:0] status;
      rsp_src_type         src;
   } bpq_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic scan_done;
   } bpq_stat_type;

endpackage

>>> src/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded priority queue controller
// Accepts commands, sequences the datapath operations and issues the result.
// ----------------------------------------------------------------------------
module bpq_ctrl import bpq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_cmd,
   input  bpq_stat_type     stat,
   output logic             busy,
   output bpq_ctl_type      ctl
);

   bpq_state_type    state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= CMD_APPEND;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      ctl        = '0;
      ctl.status = STATUS_OK;
      ctl.src    = RSP_ZERO;
      busy       = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               cmd_in   = req_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cmd_ff) inside
               CMD_APPEND: begin
                  ctl.respond = 1'b1;
                  if (stat.full) begin
                     ctl.status = STATUS_FULL;
                  end else begin
                     ctl.op_append = 1'b1;
                  end
               end
               CMD_INSERT: begin
                  if (stat.full) begin
                     ctl.respond = 1'b1;
                     ctl.status  = STATUS_FULL;
                  end else begin
                     ctl.op_flags = 1'b1;
                     state_in     = ST_INSERT;
                  end
               end
               CMD_POP_HEAD, CMD_ROTATE: begin
                  ctl.respond = 1'b1;
                  if (stat.empty) begin
                     ctl.status = STATUS_EMPTY;
                     ctl.src    = RSP_ONES;
                  end else begin
                     ctl.src       = RSP_HEAD;
                     ctl.op_remove = (cmd_ff == CMD_POP_HEAD);
                     ctl.op_rotate = (cmd_ff == CMD_ROTATE);
                  end
               end
               CMD_POP_MAX: begin
                  if (stat.empty) begin
                     ctl.respond = 1'b1;
                     ctl.status  = STATUS_EMPTY;
                     ctl.src     = RSP_ONES;
                  end else begin
                     ctl.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               CMD_CLEAR: begin
                  ctl.op_clear = 1'b1;
                  ctl.respond  = 1'b1;
               end
               default: begin
                  ctl.respond = 1'b1;
               end
            endcase
         end
         ST_INSERT: begin
            ctl.op_insert = 1'b1;
            ctl.respond   = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               ctl.op_remove = 1'b1;
               ctl.use_best  = 1'b1;
               ctl.respond   = 1'b1;
               ctl.src       = RSP_BEST;
               state_in      = ST_IDLE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/bpq_datapath.sv
// ----------------------------------------------------------------------------
// Bounded priority queue datapath
// Row of entry cells with per-cell insert and remove shifting, the entry
// count, the capacity register, the highest-priority scan and the result.
// ----------------------------------------------------------------------------
module bpq_datapath import bpq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic        [COUNT_W-1:0]  csr_data,
   input  logic signed [VALUE_W-1:0]  item_value,
   input  logic        [PRIO_W-1:0]   item_priority,
   input  bpq_ctl_type                ctl,
   output bpq_stat_type               stat,
   output logic                       rsp_strobe,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [COUNT_W-1:0]  rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic signed [VALUE_W-1:0] val_ff [DEPTH];
   logic        [PRIO_W-1:0]  pri_ff [DEPTH];
   logic signed [VALUE_W-1:0] prev_val [DEPTH];
   logic        [PRIO_W-1:0]  prev_pri [DEPTH];
   logic signed [VALUE_W-1:0] next_val [DEPTH];
   logic        [PRIO_W-1:0]  next_pri [DEPTH];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [COUNT_W-1:0]        cap_ff;
   logic signed [VALUE_W-1:0] item_val_ff;
   logic [PRIO_W-1:0]         item_pri_ff;
   logic [DEPTH-1:0]          flag_ff, flag_in, above, ins_here, ins_shift;
   logic [CNT_W-1:0]          scan_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [PRIO_W-1:0]         best_pri_ff;
   logic signed [VALUE_W-1:0] best_val_ff;

   logic                       rsp_strobe_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic        [COUNT_W-1:0]  rsp_count_ff;
   logic                       rsp_empty_ff, rsp_full_ff;

   logic [CMP_W-1:0]          cap_ext, eff_cap;
   logic [IDX_W-1:0]          scan_idx, rm_idx, tail_idx;
   logic [PRIO_W-1:0]         scan_pri;
   logic signed [VALUE_W-1:0] scan_val;

   // Neighbor taps and the insert position, cell by cell. A cell shifts up
   // when no entry at or above its lower neighbor ranks at least as high.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign flag_in[i] = (CNT_W'(i) < count_ff) && (item_pri_ff <= pri_ff[i]);
      if (i == 0) begin : g_first
         assign prev_val[i]  = '0;
         assign prev_pri[i]  = '0;
         assign ins_here[i]  = !above[i];
         assign ins_shift[i] = 1'b0;
      end else begin : g_rest
         assign prev_val[i]  = val_ff[i-1];
         assign prev_pri[i]  = pri_ff[i-1];
         assign ins_here[i]  = flag_ff[i-1] && !above[i];
         assign ins_shift[i] = !above[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_val[i] = '0;
         assign next_pri[i] = '0;
         assign above[i]    = flag_ff[i];
      end else begin : g_inner
         assign next_val[i] = val_ff[i+1];
         assign next_pri[i] = pri_ff[i+1];
         assign above[i]    = flag_ff[i] | above[i+1];
      end
   end

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign scan_idx = scan_ff[IDX_W-1:0];
   assign scan_pri = pri_ff[scan_idx];
   assign scan_val = val_ff[scan_idx];
   assign rm_idx   = ctl.use_best ? best_idx_ff : '0;
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));

   assign stat.full      = (CMP_W'(count_ff) >= eff_cap);
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = (scan_ff >= count_ff);

   always_comb begin
      count_in = count_ff;
      if (ctl.op_append || ctl.op_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.op_remove) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctl.op_clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      case (ctl.src)
         RSP_ONES: rsp_value_in = '1;
         RSP_HEAD: rsp_value_in = val_ff[0];
         RSP_BEST: rsp_value_in = best_val_ff;
         default:  rsp_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (ctl.op_append) begin
            if (count_ff == CNT_W'(i)) begin
               val_ff[i] <= item_val_ff;
               pri_ff[i] <= item_pri_ff;
            end
         end else if (ctl.op_insert) begin
            if (ins_here[i]) begin
               val_ff[i] <= item_val_ff;
               pri_ff[i] <= item_pri_ff;
            end else if (ins_shift[i]) begin
               val_ff[i] <= prev_val[i];
               pri_ff[i] <= prev_pri[i];
            end
         end else if (ctl.op_remove) begin
            if (IDX_W'(i) >= rm_idx) begin
               val_ff[i] <= next_val[i];
               pri_ff[i] <= next_pri[i];
            end
         end else if (ctl.op_rotate) begin
            if (IDX_W'(i) == tail_idx) begin
               val_ff[i] <= val_ff[0];
               pri_ff[i] <= pri_ff[0];
            end else begin
               val_ff[i] <= next_val[i];
               pri_ff[i] <= next_pri[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cap_ff        <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= ctl.respond;
         if (csr_we) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         item_val_ff <= item_value;
         item_pri_ff <= item_priority;
      end
      if (ctl.op_flags) begin
         flag_ff <= flag_in;
      end
      if (ctl.scan_init) begin
         scan_ff     <= CNT_W'(1);
         best_idx_ff <= '0;
         best_pri_ff <= pri_ff[0];
         best_val_ff <= val_ff[0];
      end else if (ctl.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
         if (scan_pri > best_pri_ff) begin
            best_idx_ff <= scan_idx;
            best_pri_ff <= scan_pri;
            best_val_ff <= scan_val;
         end
      end
      if (ctl.respond) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= ctl.status;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (CMP_W'(count_in) >= eff_cap);
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_is_full  = rsp_full_ff;

endmodule

>>> src/bounded_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Bounded priority queue unit
// Fixed-capacity ordered store of value and priority entries with append,
// priority insert, pop head, pop highest, rotate and clear commands.
// ----------------------------------------------------------------------------
// Sequence: an accepted command enters the execute state; append, pop head, rotate,
// clear and any full or empty case respond there, priority insert responds from
// the insert state, and pop highest walks the scan state over the stored entries.
// The result and its strobe are registered as the command responds. A new command
// is accepted only from idle, so a long pop highest scan holds off the next one.
// Reset clears the count and sets capacity to 16; no clearing pass is needed.
// The receiver cannot stall, so each result strobe lasts exactly one cycle.
module bounded_priority_queue_unit import bpq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // Command transaction.
   input  logic                       start,
   output logic                       busy,
   input  logic        [CMD_W-1:0]    req_cmd,
   input  logic signed [VALUE_W-1:0]  req_item_value,
   input  logic        [PRIO_W-1:0]   req_item_priority,
   // Result transaction.
   output logic                       rsp_strobe,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [COUNT_W-1:0]  rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full,
   // Capacity register write.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [COUNT_W-1:0]  csr_capacity
);

   bpq_ctl_type  ctl;
   bpq_stat_type stat;

   // Capacity is only written between transactions, so the port is ready
   // whenever the controller sits idle.
   assign csr_ready = !busy;

   // The controller owns sequencing: it latches the command, decides from
   // the full and empty status which datapath operations to run, walks the
   // scan for pop highest and raises the response load.
   bpq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .busy    (busy),
      .ctl     (ctl)
   );

   // The datapath holds the entries as a row of cells. Insert and remove
   // shift every affected cell together; the result registers sit at
   // its output so the next command can start while a result is shown.
   bpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_valid && csr_ready),
      .csr_data      (csr_capacity),
      .item_value    (req_item_value),
      .item_priority (req_item_priority),
      .ctl           (ctl),
      .stat          (stat),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full)
   );

endmodule

>>> src/bpq_checker.sv
// ----------------------------------------------------------------------------
// Bounded priority queue port checker
// Watches the top-level ports for result consistency and command sequencing.
// ----------------------------------------------------------------------------
module bpq_checker import bpq_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic signed [VALUE_W-1:0]  rsp_out_value,
   input logic        [STATUS_W-1:0] rsp_status,
   input logic        [COUNT_W-1:0]  rsp_count,
   input logic                       rsp_is_empty
);

   // The empty flag always agrees with the reported count.
   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // An accepted command keeps the unit busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a command");

   // A result only closes out work that was in progress.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result without a command in progress");

   // Results are never back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An empty pop returns all ones and leaves the store empty.
   a_empty_pop_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_EMPTY)) |-> ((rsp_out_value == -32'sd1) && rsp_is_empty))
      else $error("empty pop returned a bad value");

endmodule

bind bounded_priority_queue_unit bpq_checker u_bpq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_out_value (rsp_out_value),
   .rsp_status    (rsp_status),
   .rsp_count     (rsp_count),
   .rsp_is_empty  (rsp_is_empty)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Bounded priority queue unit testbench
// Drives append, priority insert, pop head, pop highest, rotate, clear and the
// unused command codes through the command port. Capacity is reprogrammed
// between phases, including the saturating extremes. A shadow copy of the
// ordered store predicts every result, and the results are checked field by
// field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
   import bpq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_TICKS = 40;

   // The two command codes that the unit must ignore.
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_EMPTY = -32'sd1;

   // Kinds of entries in the stimulus list: a command transaction, a capacity
   // write (only issued once the unit has drained), or a plain pause until
   // every outstanding result has arrived.
   typedef enum logic [1:0] {
      STEP_COMMAND,
      STEP_CAPACITY,
      STEP_SETTLE
   } step_kind_type;

   typedef struct {
      step_kind_type              kind;
      logic [CMD_W-1:0]           cmd;
      logic signed [VALUE_W-1:0]  value;
      logic [PRIO_W-1:0]          prio;
      logic [COUNT_W-1:0]         capacity;
      int                         gap;
   } queue_step_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_W-1:0]         count;
      logic                       is_empty;
      logic                       is_full;
   } queue_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic        [CMD_W-1:0]    req_cmd = CMD_APPEND;
   logic signed [VALUE_W-1:0]  req_item_value = '0;
   logic        [PRIO_W-1:0]   req_item_priority = '0;
   logic                       rsp_strobe;
   logic signed [VALUE_W-1:0]  rsp_out_value;
   logic        [STATUS_W-1:0] rsp_status;
   logic        [COUNT_W-1:0]  rsp_count;
   logic                       rsp_is_empty;
   logic                       rsp_is_full;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic        [COUNT_W-1:0]  csr_capacity = CAP_RESET;

   // Stimulus still to be sent and results still owed by the unit.
   queue_step_type   queued_steps[$];
   queue_result_type due_results[$];

   // Shadow of the ordered store: slot 0 is the head.
   logic signed [VALUE_W-1:0] shadow_value[QUEUE_DEPTH];
   logic [PRIO_W-1:0]         shadow_prio[QUEUE_DEPTH];
   int                        shadow_count = 0;
   logic [COUNT_W-1:0]        shadow_capacity = CAP_RESET;

   int idle_ticks  = 0;
   int error_count = 0;
   int cycle_count = 0;

   bounded_priority_queue_unit #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_capacity      (csr_capacity)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The programmed capacity saturates into 1..QUEUE_DEPTH.
   function automatic int usable_capacity();
      if (shadow_capacity == 0) return 1;
      if (shadow_capacity > QUEUE_DEPTH) return QUEUE_DEPTH;
      return int'(shadow_capacity);
   endfunction

   // Applies one accepted command to the shadow store and returns the result
   // the unit owes for it.
   function automatic queue_result_type queue_command_result(
      input logic [CMD_W-1:0]          cmd,
      input logic signed [VALUE_W-1:0] value,
      input logic [PRIO_W-1:0]         prio
   );
      queue_result_type r;
      int               slot;
      logic [PRIO_W-1:0] taken_prio;
      r        = '0;
      r.status = STATUS_OK;
      case (cmd) inside
         CMD_APPEND, CMD_INSERT: begin
            if (shadow_count >= usable_capacity()) begin
               r.status = STATUS_FULL;
            end else begin
               slot = shadow_count;
               if (cmd == CMD_INSERT) begin
                  // Goes just behind the last entry of equal or higher priority.
                  slot = 0;
                  for (int i = 0; i < shadow_count; i++)
                     if (prio <= shadow_prio[i]) slot = i + 1;
                  for (int i = shadow_count; i > slot; i--) begin
                     shadow_value[i] = shadow_value[i-1];
                     shadow_prio[i]  = shadow_prio[i-1];
                  end
               end
               shadow_value[slot] = value;
               shadow_prio[slot]  = prio;
               shadow_count++;
            end
         end
         CMD_POP_HEAD, CMD_POP_MAX, CMD_ROTATE: begin
            if (shadow_count == 0) begin
               r.value  = VALUE_EMPTY;
               r.status = STATUS_EMPTY;
            end else begin
               slot = 0;
               // Ties keep the entry nearest the head.
               if (cmd == CMD_POP_MAX)
                  for (int i = 1; i < shadow_count; i++)
                     if (shadow_prio[i] > shadow_prio[slot]) slot = i;
               r.value    = shadow_value[slot];
               taken_prio = shadow_prio[slot];
               for (int i = slot + 1; i < shadow_count; i++) begin
                  shadow_value[i-1] = shadow_value[i];
                  shadow_prio[i-1]  = shadow_prio[i];
               end
               shadow_count--;
               if (cmd == CMD_ROTATE) begin
                  shadow_value[shadow_count] = r.value;
                  shadow_prio[shadow_count]  = taken_prio;
                  shadow_count++;
               end
            end
         end
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.count    = COUNT_W'(shadow_count);
      r.is_empty = (shadow_count == 0);
      r.is_full  = (shadow_count >= usable_capacity());
      return r;
   endfunction

   // Sender. Commands go out back to back unless a gap is pending; a capacity
   // write waits until the unit has returned every result and is idle.
   always @(posedge clock) begin
      logic next_start;
      logic next_csr;
      next_start = start;
      next_csr   = csr_valid;
      if (reset) begin
         next_start = 1'b0;
         next_csr   = 1'b0;
         idle_ticks = 0;
      end else begin
         if (start && !busy) begin
            due_results.push_back(queue_command_result(req_cmd, req_item_value,
                                                       req_item_priority));
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            shadow_capacity = csr_capacity;
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr && queued_steps.size() != 0) begin
            if (idle_ticks > 0) begin
               idle_ticks--;
            end else begin
               case (queued_steps[0].kind)
                  STEP_COMMAND: begin
                     req_cmd           <= queued_steps[0].cmd;
                     req_item_value    <= queued_steps[0].value;
                     req_item_priority <= queued_steps[0].prio;
                     next_start = 1'b1;
                     idle_ticks = queued_steps[0].gap;
                     void'(queued_steps.pop_front());
                  end
                  STEP_CAPACITY: begin
                     if (due_results.size() == 0 && !busy) begin
                        csr_capacity <= queued_steps[0].capacity;
                        next_csr = 1'b1;
                        void'(queued_steps.pop_front());
                     end
                  end
                  default: begin
                     if (due_results.size() == 0) void'(queued_steps.pop_front());
                  end
               endcase
            end
         end
      end
      start     <= next_start;
      csr_valid <= next_csr;
   end

   // Receiver. A strobe cannot be held off, so every strobed cycle is one
   // result transaction and is matched against the oldest owed result.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_strobe) begin
         if (due_results.size() == 0) begin
            $error("unexpected result transaction: out_value %0d status %0d count %0d",
                   rsp_out_value, rsp_status, rsp_count);
            error_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, actual %0d", want.value, rsp_out_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_count);
               error_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0b, actual %0b", want.is_empty, rsp_is_empty);
               error_count++;
            end
            if (rsp_is_full !== want.is_full) begin
               $error("is_full: expected %0b, actual %0b", want.is_full, rsp_is_full);
               error_count++;
            end
         end
      end
   end

   task automatic add_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [VALUE_W-1:0] value,
                              input logic [PRIO_W-1:0] prio, input int gap);
      queue_step_type s;
      s.kind     = STEP_COMMAND;
      s.cmd      = cmd;
      s.value    = value;
      s.prio     = prio;
      s.capacity = '0;
      s.gap      = gap;
      queued_steps.push_back(s);
   endtask

   task automatic add_capacity(input logic [COUNT_W-1:0] capacity);
      queue_step_type s;
      s.kind     = STEP_CAPACITY;
      s.cmd      = CMD_APPEND;
      s.value    = '0;
      s.prio     = '0;
      s.capacity = capacity;
      s.gap      = 0;
      queued_steps.push_back(s);
   endtask

   task automatic add_settle();
      queue_step_type s;
      s.kind     = STEP_SETTLE;
      s.cmd      = CMD_APPEND;
      s.value    = '0;
      s.prio     = '0;
      s.capacity = '0;
      s.gap      = 0;
      queued_steps.push_back(s);
   endtask

   // Values lean on the sign boundaries now and then.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return VALUE_EMPTY;
         default: return $urandom;
      endcase
   endfunction

   // Narrow priorities make ties common, which is where insert order and
   // the pop-highest tie rule matter.
   function automatic logic [PRIO_W-1:0] pick_prio();
      case ($urandom_range(0, 9)) inside
         0, 1, 2, 3: return PRIO_W'($urandom_range(0, 3));
         4: return 16'hFFFF;
         5: return 16'h0000;
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   // A filling stretch favors pushes so the store reaches full; a draining
   // stretch favors removals so it reaches empty.
   function automatic logic [CMD_W-1:0] pick_command(input bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return CMD_CLEAR;
      if (r < 4) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
      if ($urandom_range(0, 99) < (filling ? 70 : 30))
         return ($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_APPEND;
      case ($urandom_range(0, 2))
         0: return CMD_POP_HEAD;
         1: return CMD_POP_MAX;
         default: return CMD_ROTATE;
      endcase
   endfunction

   // Mostly no gap or a short one, with an occasional long stall.
   function automatic int pick_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      logic [COUNT_W-1:0] capacity_plan[14];
      bit                 filling;
      bit                 steady;
      capacity_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd17,
                        5'd3, 5'd8, 5'd15, 5'd16, 5'd4, 5'd16, 5'd1};

      // Directed part. Removals on an empty store come first.
      add_command(CMD_POP_HEAD, 32'sd7, 16'd1, 0);
      add_command(CMD_POP_MAX, 32'sd7, 16'd1, 0);
      add_command(CMD_ROTATE, 32'sd7, 16'd1, 0);
      add_command(CMD_APPEND, 32'sh7FFF_FFFF, 16'h0000, 0);
      add_command(CMD_APPEND, 32'sh8000_0000, 16'hFFFF, 0);
      // Equal top priority lands behind the existing one.
      add_command(CMD_INSERT, VALUE_EMPTY, 16'hFFFF, 1);
      add_command(CMD_INSERT, 32'sd0, 16'h0000, 0);
      add_command(CMD_INSERT, 32'sh1234_5678, 16'h8000, 0);
      // Two entries share the top priority: the one nearer the head goes.
      add_command(CMD_POP_MAX, 32'sd0, 16'd0, 0);
      add_command(CMD_ROTATE, 32'sd0, 16'd0, 2);
      add_command(CMD_POP_HEAD, 32'sd0, 16'd0, 0);
      add_command(CMD_SPARE_6, 32'sh5555_5555, 16'h5555, 0);
      add_command(CMD_SPARE_7, 32'shAAAA_AAAA, 16'hAAAA, 0);
      add_command(CMD_CLEAR, 32'sd0, 16'd0, 0);
      // A priority above every entry goes to the head.
      add_command(CMD_APPEND, 32'sd11, 16'd10, 0);
      add_command(CMD_INSERT, 32'sd22, 16'd20, 0);
      add_command(CMD_INSERT, 32'sd33, 16'd10, 0);
      // Capacity lowered below the count: full, and pushes are dropped.
      add_capacity(5'd1);
      add_command(CMD_APPEND, 32'sd44, 16'd5, 0);
      add_command(CMD_CLEAR, 32'sd0, 16'd0, 0);
      add_command(CMD_INSERT, 32'sd55, 16'd3, 0);
      add_command(CMD_APPEND, 32'sd66, 16'd3, 0);
      // Zero acts as one and anything above the depth acts as the depth.
      add_capacity(5'd0);
      add_command(CMD_INSERT, 32'sd77, 16'd9, 0);
      add_command(CMD_POP_MAX, 32'sd0, 16'd0, 0);
      add_capacity(5'd31);
      add_command(CMD_APPEND, 32'sd88, 16'd9, 0);
      add_command(CMD_ROTATE, 32'sd0, 16'd0, 0);

      // Random part: one capacity setting per phase. The capacity write also
      // makes the sender wait until every owed result has come back.
      for (int phase = 0; phase < 14; phase++) begin
         steady = ($urandom_range(0, 3) == 0);
         if (phase >= 10 && $urandom_range(0, 1) != 0)
            add_capacity(COUNT_W'($urandom_range(0, 31)));
         else
            add_capacity(capacity_plan[phase]);
         filling = 1'b1;
         for (int n = 0; n < 125; n++) begin
            if (n % 20 == 0 && n != 0) filling = ($urandom_range(0, 1) != 0);
            add_command(pick_command(filling), pick_value(), pick_prio(), pick_gap(steady));
            if ($urandom_range(0, 199) == 0) add_settle();
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cycle_count < CYCLE_LIMIT &&
             !(queued_steps.size() == 0 && !start && !csr_valid && due_results.size() == 0))
         @(posedge clock);
      if (cycle_count < CYCLE_LIMIT) repeat (SETTLE_TICKS) @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles", cycle_count);
         error_count++;
      end
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         error_count++;
      end

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
src/bpq_pkg.sv
src/bpq_ctrl.sv
src/bpq_datapath.sv
src/bounded_priority_queue_unit.sv
src/bpq_checker.sv
test/testbench.sv
